// ===== src/tpg_pkg.sv =====
// Package for the test pattern pixel generator.
// Holds shared constants, register indexes, mode codes and pipeline structs.
// No dependencies.
package tpg_pkg;

    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 13;

    // divider widths: numerator magnitude below 2**25, divisor below 2**14
    localparam int unsigned DIV_NB    = 25;
    localparam int unsigned DIV_DB    = 14;
    localparam int unsigned NUM_W     = 27;
    localparam int unsigned N_DIV     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0] MODE_BILEVEL = 2'd0;
    localparam logic [1:0] MODE_GRAY    = 2'd1;
    localparam logic [1:0] MODE_COLOR   = 2'd2;

    localparam logic [1:0] BAR_FIRST  = 2'd0;
    localparam logic [1:0] BAR_SECOND = 2'd1;
    localparam logic [1:0] BAR_THIRD  = 2'd2;

    typedef logic signed [NUM_W-1:0] t_num;

    typedef struct packed {
        logic               outside;
        logic               in_rect;
        logic [COORD_W-1:0] col;
        logic [13:0]        ro;
        logic               co_neg;
        logic               upper;
        logic [1:0]         bar;
    } t_side;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               bilevel_bit;
        logic               size_error;
        logic               outside_frame;
    } t_pix;

endpackage

// ===== src/tpg_in_if.sv =====
// Input channel: one pixel coordinate per beat.
// Depends on tpg_pkg.
interface tpg_in_if;
    import tpg_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;

    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// ===== src/tpg_out_if.sv =====
// Output channel: one generated pixel per beat.
// Depends on tpg_pkg.
interface tpg_out_if;
    import tpg_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               bilevel_bit;
    logic               size_error;
    logic               outside_frame;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    output bilevel_bit, output size_error, output outside_frame,
                    input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    input bilevel_bit, input size_error, input outside_frame,
                    output ready);
endinterface

// ===== src/tpg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating signed result.
// Depends on nothing; a zero divisor raises o_zero.
module tpg_div #(
    parameter int unsigned NB = 25,
    parameter int unsigned DB = 14
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_num_neg,
    input  logic [NB-1:0]        i_num_mag,
    input  logic                 i_den_neg,
    input  logic [DB-1:0]        i_den_mag,
    output logic signed [NB:0]   o_quo,
    output logic                 o_zero
);
    logic [DB-1:0] r_rem  [0:NB];
    logic [NB-1:0] r_num  [0:NB];
    logic [NB-1:0] r_quo  [0:NB];
    logic [DB-1:0] r_den  [0:NB];
    logic          r_neg  [0:NB];
    logic          r_zero [0:NB];

    always_ff @(posedge i_clk) begin
        logic [DB:0] t;
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num_mag;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den_mag;
            r_neg[0]  <= i_num_neg ^ i_den_neg;
            r_zero[0] <= (i_den_mag == '0);
            for (int k = 1; k <= NB; k++) begin
                t = {r_rem[k-1], r_num[k-1][NB-1]};
                if (t >= {1'b0, r_den[k-1]}) begin
                    t        = t - {1'b0, r_den[k-1]};
                    r_quo[k] <= {r_quo[k-1][NB-2:0], 1'b1};
                end else begin
                    r_quo[k] <= {r_quo[k-1][NB-2:0], 1'b0};
                end
                r_rem[k]  <= t[DB-1:0];
                r_num[k]  <= {r_num[k-1][NB-2:0], 1'b0};
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    always_comb begin
        o_zero = r_zero[NB];
        if (r_neg[NB]) begin
            o_quo = -$signed({1'b0, r_quo[NB]});
        end else begin
            o_quo = $signed({1'b0, r_quo[NB]});
        end
    end
endmodule

// ===== src/test_pattern_pixel_generator.sv =====
// Test pattern pixel generator: top level.
// Depends on tpg_pkg, tpg_in_if, tpg_out_if and tpg_div.
//
// Use: write pattern_mode (index 0), frame_width (1) and frame_height (2)
// through i_cfg_we / i_cfg_idx / i_cfg_data while no pixel is in flight.
// Send coordinate beats on i_px (pixel_row, pixel_col); each gives exactly
// one pixel beat on o_px, in order.
// Throughput: one beat per clock while o_px.ready stays high. The pipeline
// has 30 register stages: the input stage, the product stage, the divider
// pipeline (a load stage and 25 quotient-bit stages, five dividers side by
// side), the select stage and the output register.
// Reset returns the registers to gray mode, 480 x 480, and empties the
// pipeline. When the receiver stalls, a skid register takes the one beat
// in flight and then the whole pipeline holds; i_px.ready drops only while
// the skid register is full, so no beat is lost or repeated.
module test_pattern_pixel_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpg_pkg::CFG_DAT_W-1:0] i_cfg_data,
    tpg_in_if.sink                        i_px,
    tpg_out_if.source                     o_px
);
    import tpg_pkg::*;

    // configuration
    logic [1:0]       r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GRAY;
            r_width  <= 13'd480;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // geometry derived from configuration
    logic [11:0]        r_rw, r_rh, r_up;
    logic [12:0]        r_up2, r_hlow;
    logic signed [14:0] r_left, r_right, r_top, r_bottom, r_wm1;
    logic               r_size_bad;
    logic               r_rden_neg [1:4];
    logic [DIV_DB-1:0]  r_rden_mag [1:4];

    always_ff @(posedge i_clk) begin
        logic [11:0]        rw, rh;
        logic [12:0]        left, top;
        logic [26:0]        prod3;
        logic [11:0]        up;
        logic [13:0]        up3;
        logic               hbad, wbad;
        logic signed [14:0] d [1:4];
        rw    = r_width[12:1];
        rh    = r_height[12:1];
        left  = (r_width - {1'b0, rw}) >> 1;
        top   = (r_height - {1'b0, rh}) >> 1;
        prod3 = 27'(r_width) * 27'd10923;
        up    = prod3[26:15];
        up3   = {1'b0, up, 1'b0} + {2'b00, up};
        hbad  = (r_height < 13'd4) || (r_height[1:0] != 2'b00) || (r_height > 13'(MAX_DIM));
        if (r_mode == MODE_COLOR) begin
            wbad = (r_width < 13'd6) || r_width[0] || (up3 != {1'b0, r_width});
        end else begin
            wbad = (r_width < 13'd4) || (r_width[1:0] != 2'b00);
        end
        wbad = wbad || (r_width > 13'(MAX_DIM));
        d[1] = $signed({3'b000, rh}) - $signed({2'b00, top});
        d[2] = $signed({2'b00, top}) - 15'sd1;
        d[3] = $signed({3'b000, rw}) - $signed({2'b00, left});
        d[4] = $signed({2'b00, left}) - 15'sd1;
        r_rw       <= rw;
        r_rh       <= rh;
        r_up       <= up;
        r_up2      <= {up, 1'b0};
        r_hlow     <= r_height - {1'b0, rh};
        r_left     <= $signed({2'b00, left});
        r_top      <= $signed({2'b00, top});
        r_right    <= $signed({2'b00, left}) + $signed({3'b000, rw}) - 15'sd1;
        r_bottom   <= $signed({2'b00, top}) + $signed({3'b000, rh}) - 15'sd1;
        r_wm1      <= $signed({2'b00, r_width}) - 15'sd1;
        r_size_bad <= hbad || wbad;
        for (int k = 1; k <= 4; k++) begin
            r_rden_neg[k] <= d[k][14];
            r_rden_mag[k] <= d[k][14] ? DIV_DB'(-d[k]) : DIV_DB'(d[k]);
        end
    end

    // output side and pipeline enable
    logic r_skid_v, r_out_v, r_vf;
    t_pix r_skid, r_out, r_fout;
    logic en;
    assign en        = !r_skid_v;
    assign i_px.ready = en;

    // stage 0: input register
    logic               r_v0;
    logic [COORD_W-1:0] r_row, r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_px.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_row <= i_px.pixel_row;
            r_col <= i_px.pixel_col;
        end
    end

    // stage 1: compares and numerators
    logic              r_v1;
    t_num              r_n [0:N_DIV-1];
    logic [DIV_DB-1:0] r_den0;
    t_side             r_side1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [14:0] rs, cs, ro, co;
        logic               upper;
        t_side              s;
        rs    = $signed({3'b000, r_row});
        cs    = $signed({3'b000, r_col});
        ro    = rs - $signed({3'b000, r_rh});
        co    = cs - $signed({3'b000, r_rw});
        upper = {1'b0, r_row} < {1'b0, r_rh};
        s.outside = ({1'b0, r_row} >= r_height) || ({1'b0, r_col} >= r_width);
        s.in_rect = (rs >= r_top) && (rs <= r_bottom) && (cs >= r_left) && (cs <= r_right);
        s.col     = r_col;
        s.ro      = ro[13:0];
        s.co_neg  = co[14];
        s.upper   = upper;
        if (upper) begin
            if ({1'b0, r_col} < {1'b0, r_up}) begin
                s.bar = BAR_FIRST;
            end else if ({1'b0, r_col} < r_up2) begin
                s.bar = BAR_SECOND;
            end else begin
                s.bar = BAR_THIRD;
            end
        end else begin
            s.bar = ({1'b0, r_col} < {1'b0, r_rw}) ? BAR_FIRST : BAR_SECOND;
        end
        if (en) begin
            r_side1 <= s;
            case (r_mode)
                MODE_BILEVEL: begin
                    r_n[0] <= $signed(NUM_W'(r_row) * NUM_W'(r_width));
                    r_den0 <= DIV_DB'(r_height);
                end
                MODE_GRAY: begin
                    r_n[0] <= NUM_W'(co) * $signed(NUM_W'(r_rh));
                    r_den0 <= DIV_DB'(r_rw);
                end
                default: begin
                    if (upper) begin
                        r_n[0] <= $signed(NUM_W'(r_row) * NUM_W'(255));
                        r_den0 <= DIV_DB'(r_rh);
                    end else begin
                        r_n[0] <= $signed(NUM_W'(r_row) - NUM_W'(r_rh)) * 27'sd255;
                        r_den0 <= DIV_DB'(r_hlow);
                    end
                end
            endcase
            r_n[1] <= NUM_W'(rs - r_top) * 27'sd255;
            r_n[2] <= NUM_W'(ro) * 27'sd255;
            r_n[3] <= NUM_W'(cs - r_left) * 27'sd255;
            r_n[4] <= NUM_W'(co) * 27'sd255;
        end
    end

    // dividers
    logic signed [DIV_NB:0] q [0:N_DIV-1];
    logic                   qz [0:N_DIV-1];

    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        logic              num_neg;
        logic [DIV_NB-1:0] num_mag;
        logic              den_neg;
        logic [DIV_DB-1:0] den_mag;
        t_num              nabs;
        assign num_neg = r_n[g][NUM_W-1];
        assign nabs    = num_neg ? -r_n[g] : r_n[g];
        assign num_mag = nabs[DIV_NB-1:0];
        if (g == 0) begin : g_d0
            assign den_neg = 1'b0;
            assign den_mag = r_den0;
        end else begin : g_dr
            assign den_neg = r_rden_neg[g];
            assign den_mag = r_rden_mag[g];
        end
        tpg_div #(.NB(DIV_NB), .DB(DIV_DB)) u_div (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_num_neg (num_neg),
            .i_num_mag (num_mag),
            .i_den_neg (den_neg),
            .i_den_mag (den_mag),
            .o_quo     (q[g]),
            .o_zero    (qz[g])
        );
    end

    // sideband travels beside the dividers
    logic  r_vd   [0:DIV_NB];
    t_side r_side [0:DIV_NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_NB; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (en) begin
            r_vd[0] <= r_v1;
            for (int k = 1; k <= DIV_NB; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_side1;
            for (int k = 1; k <= DIV_NB; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // select stage
    function automatic logic [LEVEL_W-1:0] sat8(input logic signed [DIV_NB+2:0] v);
        logic [LEVEL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > 255) begin
            res = 8'd255;
        end else begin
            res = v[LEVEL_W-1:0];
        end
        return res;
    endfunction

    t_pix n_fout;

    always_comb begin
        logic signed [DIV_NB+2:0] qv [0:N_DIV-1];
        logic signed [DIV_NB+2:0] d1, d2, ro, cx, v;
        logic [LEVEL_W-1:0]       p, g;
        t_side                    s;
        s = r_side[DIV_NB];
        for (int k = 0; k < N_DIV; k++) begin
            qv[k] = qz[k] ? (DIV_NB+3)'(255) : (DIV_NB+3)'(q[k]);
        end
        if (qz[0]) begin
            d1 = (DIV_NB+3)'(255);
            d2 = (DIV_NB+3)'(255);
        end else begin
            d1 = qv[0];
            d2 = -qv[0];
        end
        ro = (DIV_NB+3)'($signed(s.ro));
        cx = (DIV_NB+3)'({1'b0, s.col});
        if (ro <= d1 && ro <= d2) begin
            v = 255 - qv[1];
        end else if (ro >= d1 && ro >= d2) begin
            v = qv[2];
        end else if (s.co_neg) begin
            v = 255 - qv[3];
        end else begin
            v = qv[4];
        end
        g = s.in_rect ? sat8(v) : '0;
        p = sat8(qv[0]);

        n_fout               = '0;
        n_fout.size_error    = r_size_bad;
        n_fout.outside_frame = s.outside;
        if (!s.outside) begin
            case (r_mode)
                MODE_BILEVEL: begin
                    if (cx == qv[0] || cx == (DIV_NB+3)'(r_wm1) - qv[0]) begin
                        n_fout.bilevel_bit = 1'b1;
                    end else begin
                        n_fout.bilevel_bit = !s.in_rect;
                    end
                end
                MODE_GRAY: begin
                    n_fout.red_level   = g;
                    n_fout.green_level = g;
                    n_fout.blue_level  = g;
                end
                MODE_COLOR: begin
                    if (s.upper) begin
                        case (s.bar)
                            BAR_FIRST: begin
                                n_fout.red_level   = 8'd255;
                                n_fout.green_level = p;
                                n_fout.blue_level  = p;
                            end
                            BAR_SECOND: begin
                                n_fout.red_level   = 8'd255 - p;
                                n_fout.green_level = 8'd255;
                                n_fout.blue_level  = 8'd255 - p;
                            end
                            default: begin
                                n_fout.red_level   = p;
                                n_fout.green_level = p;
                                n_fout.blue_level  = 8'd255;
                            end
                        endcase
                    end else if (s.bar == BAR_FIRST) begin
                        n_fout.red_level   = p;
                        n_fout.green_level = p;
                        n_fout.blue_level  = p;
                    end else begin
                        n_fout.red_level   = 8'd255 - p;
                        n_fout.green_level = 8'd255 - p;
                        n_fout.blue_level  = 8'd255 - p;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= r_vd[DIV_NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fout <= n_fout;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_px.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_vf;
            end
        end else if (r_vf && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_px.ready) begin
            r_out <= r_skid_v ? r_skid : r_fout;
        end else if (en) begin
            r_skid <= r_fout;
        end
    end

    assign o_px.valid         = r_out_v;
    assign o_px.red_level     = r_out.red_level;
    assign o_px.green_level   = r_out.green_level;
    assign o_px.blue_level    = r_out.blue_level;
    assign o_px.bilevel_bit   = r_out.bilevel_bit;
    assign o_px.size_error    = r_out.size_error;
    assign o_px.outside_frame = r_out.outside_frame;
endmodule

// ===== src/tpg_chk.sv =====
// Port-level checker for the test pattern pixel generator, with its bind.
// Depends on tpg_pkg.
module tpg_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tpg_pkg::LEVEL_W-1:0] i_red,
    input logic [tpg_pkg::LEVEL_W-1:0] i_green,
    input logic [tpg_pkg::LEVEL_W-1:0] i_blue,
    input logic                        i_bit,
    input logic                        i_outside
);
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outside |->
            i_red == '0 && i_green == '0 && i_blue == '0 && !i_bit)
        else $error("pixel outside frame carries levels");

    a_bit_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bit |-> i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("bilevel pixel carries color levels");

    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |=> i_in_ready)
        else $error("input held off with empty output");
endmodule

bind test_pattern_pixel_generator tpg_chk u_tpg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_px.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_red       (o_px.red_level),
    .i_green     (o_px.green_level),
    .i_blue      (o_px.blue_level),
    .i_bit       (o_px.bilevel_bit),
    .i_outside   (o_px.outside_frame)
);
